>>> src/line_endpoint_clipper_defines.svh
// Assertion macros shared by the clipper RTL
`ifndef LINE_ENDPOINT_CLIPPER_DEFINES_SVH
`define LINE_ENDPOINT_CLIPPER_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define LEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("line_endpoint_clipper: check failed");

// Condition in one cycle implies consequence in the next
`define LEC_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("line_endpoint_clipper: sequence check failed");

`endif

>>> src/lec_pkg.sv
`default_nettype none

package lec_pkg;

  localparam int LEC_COORD_BITS = 16;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } skid_ctl_t;

endpackage

`default_nettype wire

>>> src/lec_div.sv
`default_nettype none

module lec_div #(
  parameter int NB = 32,
  parameter int DB = 16,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NB-1:0] dividend,
  input  wire logic [DB-1:0] divisor,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NB-1:0]      quot,
  output logic [SW-1:0]      out_side
);

  logic [NB-1:0] dv [0:NB];
  logic [DB-1:0] rm [0:NB];
  logic [DB-1:0] ds [0:NB];
  logic [SW-1:0] sd [0:NB];
  logic [NB:0]   vl;

  assign dv[0] = dividend;
  assign rm[0] = '0;
  assign ds[0] = divisor;
  assign sd[0] = in_side;
  assign vl[0] = in_valid;

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [DB:0] t;
    logic [DB:0] diff;
    logic        ge;

    always_comb begin
      t    = {rm[k], dv[k][NB-1]};
      diff = t - {1'b0, ds[k]};
      ge   = (t >= {1'b0, ds[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k+1] <= ge ? diff[DB-1:0] : t[DB-1:0];
        dv[k+1] <= {dv[k][NB-2:0], ge};
        ds[k+1] <= ds[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vl[NB];
  assign quot      = dv[NB];
  assign out_side  = sd[NB];

endmodule

`default_nettype wire

>>> src/lec_axis.sv
`default_nettype none

module lec_axis #(
  parameter int N = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  wire logic [N-1:0] a,
  input  wire logic [N-1:0] b,
  input  wire logic [N-1:0] a1,
  input  wire logic [N-1:0] b1,
  input  wire logic [N:0]   da,
  input  wire logic [N:0]   db,
  input  wire logic [N-1:0] lo,
  input  wire logic [N-1:0] hi,
  output logic              out_valid,
  output logic [N-1:0]      a_out,
  output logic [N-1:0]      b_out,
  output logic [N-1:0]      a1_out,
  output logic [N-1:0]      b1_out,
  output logic [N:0]        da_out,
  output logic [N:0]        db_out
);

  localparam int SW = 6 * N + 4;
  localparam int PW = 2 * N + 2;

  logic         outside, cond;
  logic [N-1:0] ac;
  logic [N:0]   diff;

  always_comb begin
    ac = a;
    if ($signed(ac) < $signed(lo)) ac = lo;
    if ($signed(ac) > $signed(hi)) ac = hi;
    outside = ($signed(a) < $signed(lo)) || ($signed(a) > $signed(hi));
    cond    = outside && (da != '0);
    diff    = {ac[N-1], ac} - {a1[N-1], a1};
  end

  logic         v1, cond1;
  logic [N-1:0] an1, bo1, a1_1, b1_1;
  logic [N:0]   da1, db1, diff1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cond1 <= cond;
      an1   <= cond ? ac : a;
      bo1   <= b;
      a1_1  <= a1;
      b1_1  <= b1;
      da1   <= da;
      db1   <= db;
      diff1 <= diff;
    end
  end

  logic          v2, cond2;
  logic [N-1:0]  an2, bo2, a1_2, b1_2;
  logic [N:0]    da2, db2;
  logic [PW-1:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cond2 <= cond1;
      an2   <= an1;
      bo2   <= bo1;
      a1_2  <= a1_1;
      b1_2  <= b1_1;
      da2   <= da1;
      db2   <= db1;
      prod2 <= PW'($signed(db1) * $signed(diff1));
    end
  end

  logic          neg2;
  logic [PW-1:0] pmag;
  logic [N:0]    dmag;
  logic [SW-1:0] side_in, side_out;
  logic          dvalid;
  logic [2*N-1:0] quot;

  always_comb begin
    neg2    = prod2[PW-1] ^ da2[N];
    pmag    = prod2[PW-1] ? (PW'(0) - prod2) : prod2;
    dmag    = da2[N] ? ((N+1)'(0) - da2) : da2;
    side_in = {cond2, neg2, an2, bo2, a1_2, b1_2, da2, db2};
  end

  lec_div #(
    .NB(2 * N),
    .DB(N),
    .SW(SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .dividend (pmag[2*N-1:0]),
    .divisor  (dmag[N-1:0]),
    .in_side  (side_in),
    .out_valid(dvalid),
    .quot     (quot),
    .out_side (side_out)
  );

  logic          c3, n3;
  logic [N-1:0]  an3, bo3, a13, b13;
  logic [N:0]    da3, db3;
  logic [2*N:0]  qs;
  logic [PW-1:0] sum;
  logic [N-1:0]  bsat;
  logic [PW-1:0] smax, smin;

  always_comb begin
    {c3, n3, an3, bo3, a13, b13, da3, db3} = side_out;
    qs   = n3 ? ((2*N+1)'(0) - {1'b0, quot}) : {1'b0, quot};
    sum  = {qs[2*N], qs} + {{(N+2){b13[N-1]}}, b13};
    smax = {{(N+3){1'b0}}, {(N-1){1'b1}}};
    smin = ~smax;
    if ($signed(sum) > $signed(smax)) begin
      bsat = {1'b0, {(N-1){1'b1}}};
    end else if ($signed(sum) < $signed(smin)) begin
      bsat = {1'b1, {(N-1){1'b0}}};
    end else begin
      bsat = sum[N-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out  <= an3;
      b_out  <= c3 ? bsat : bo3;
      a1_out <= a13;
      b1_out <= b13;
      da_out <= da3;
      db_out <= db3;
    end
  end

endmodule

`default_nettype wire

>>> src/line_endpoint_clipper.sv
`default_nettype none
`include "line_endpoint_clipper_defines.svh"

// Clips the end point of a line segment against an inclusive rectangle, first in x
// (interpolating y), then in y (interpolating x). Fully pipelined: one segment per
// cycle while the output buffer is not full. Each axis uses a bit-per-stage divider
// of 2*COORD_BITS stages. A two-entry output buffer keeps taking segments while one
// result waits; input stalls only when both entries are held.
module line_endpoint_clipper #(
  parameter int COORD_BITS = lec_pkg::LEC_COORD_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // clipped_x, clipped_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_tdata,
  input  wire logic                                  cfg_we,
  input  wire lec_pkg::cfg_reg_t                     cfg_index,
  input  wire logic [COORD_BITS-1:0]                 cfg_data
);

  import lec_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int OW = ((2*COORD_BITS+7)/8)*8;

  logic [N-1:0] clip_left, clip_top, clip_right, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= {1'b0, {(N-1){1'b1}}};
      clip_bottom <= {1'b0, {(N-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   clip_left   <= cfg_data;
        REG_TOP:    clip_top    <= cfg_data;
        REG_RIGHT:  clip_right  <= cfg_data;
        REG_BOTTOM: clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [1:0] count;
  logic       adv;
  skid_ctl_t  ctl;

  assign adv      = (count != 2'd2);
  assign s_tready = adv;

  logic [N-1:0] sx, sy, ex, ey;
  logic [N:0]   dx, dy;

  assign sx = s_tdata[N-1:0];
  assign sy = s_tdata[2*N-1:N];
  assign ex = s_tdata[3*N-1:2*N];
  assign ey = s_tdata[4*N-1:3*N];
  assign dx = {ex[N-1], ex} - {sx[N-1], sx};
  assign dy = {ey[N-1], ey} - {sy[N-1], sy};

  logic         v1;
  logic [N-1:0] x1o, y1o, sx1, sy1;
  logic [N:0]   dx1, dy1;

  lec_axis #(.N(N)) u_clip_x (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s_tvalid && s_tready),
    .a        (ex),
    .b        (ey),
    .a1       (sx),
    .b1       (sy),
    .da       (dx),
    .db       (dy),
    .lo       (clip_left),
    .hi       (clip_right),
    .out_valid(v1),
    .a_out    (x1o),
    .b_out    (y1o),
    .a1_out   (sx1),
    .b1_out   (sy1),
    .da_out   (dx1),
    .db_out   (dy1)
  );

  logic         v2;
  logic [N-1:0] y2o, x2o, sy2, sx2;
  logic [N:0]   dy2, dx2;

  lec_axis #(.N(N)) u_clip_y (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v1),
    .a        (y1o),
    .b        (x1o),
    .a1       (sy1),
    .b1       (sx1),
    .da       (dy1),
    .db       (dx1),
    .lo       (clip_top),
    .hi       (clip_bottom),
    .out_valid(v2),
    .a_out    (y2o),
    .b_out    (x2o),
    .a1_out   (sy2),
    .b1_out   (sx2),
    .da_out   (dy2),
    .db_out   (dx2)
  );

  logic [OW-1:0] res, q0, q1;

  assign res      = OW'({y2o, x2o});
  assign ctl.push = v2 && adv;
  assign ctl.pop  = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, ctl.push} - {1'b0, ctl.pop};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      q0 <= (count == 2'd2) ? q1 : res;
      if (count == 2'd2 && ctl.push) q1 <= res;
    end else if (ctl.push) begin
      if (count == 2'd0) q0 <= res;
      else q1 <= res;
    end
  end

  `LEC_ASSERT(a_count_range, count != 2'd3)
  `LEC_ASSERT_NEXT(a_pop_only, ctl.pop && !ctl.push, count == $past(count) - 2'd1)
  `LEC_ASSERT_NEXT(a_push_only, ctl.push && !ctl.pop, count == $past(count) + 2'd1)
  `LEC_ASSERT_NEXT(a_stall_holds, !adv && !ctl.pop, !s_tready && $stable(q1))

endmodule

`default_nettype wire

>>> bench/tb_line_endpoint_clipper.sv
`timescale 1ns / 100ps

class clip_scoreboard;
  logic signed [15:0] left, top, right, bottom;
  logic [31:0] expected_q[$];
  int fails;
  int checked;

  function new();
    fails = 0;
    checked = 0;
    set_rect(16'sd0, 16'sd0, 16'sd32767, 16'sd32767);
  endfunction

  function void set_rect(logic signed [15:0] l, logic signed [15:0] t,
                         logic signed [15:0] r, logic signed [15:0] b);
    left = l;
    top = t;
    right = r;
    bottom = b;
  endfunction

  function longint saturate(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function logic [31:0] clip_end(logic [63:0] seg);
    longint x1, y1, x2, y2, dx, dy;
    logic signed [15:0] cx, cy;
    x1 = $signed(seg[15:0]);
    y1 = $signed(seg[31:16]);
    x2 = $signed(seg[47:32]);
    y2 = $signed(seg[63:48]);
    dx = x2 - x1;
    dy = y2 - y1;
    if ((x2 < left || x2 > right) && dx != 0) begin
      if (x2 < left) x2 = left;
      if (x2 > right) x2 = right;
      y2 = saturate(dy * (x2 - x1) / dx + y1);
    end
    if ((y2 < top || y2 > bottom) && dy != 0) begin
      if (y2 < top) y2 = top;
      if (y2 > bottom) y2 = bottom;
      x2 = saturate(dx * (y2 - y1) / dy + x1);
    end
    cx = x2[15:0];
    cy = y2[15:0];
    return {cy, cx};
  endfunction

  function void note_segment(logic [63:0] seg);
    expected_q.push_back(clip_end(seg));
  endfunction

  function void check_point(logic [31:0] got);
    logic [31:0] want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result x=%0d y=%0d", $time,
               $signed(got[15:0]), $signed(got[31:16]));
      fails++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (want[15:0] !== got[15:0]) begin
      $display("%0t: clipped_x expected %0d actual %0d", $time,
               $signed(want[15:0]), $signed(got[15:0]));
      fails++;
    end
    if (want[31:16] !== got[31:16]) begin
      $display("%0t: clipped_y expected %0d actual %0d", $time,
               $signed(want[31:16]), $signed(got[31:16]));
      fails++;
    end
  endfunction
endclass

module tb_line_endpoint_clipper;
  import lec_pkg::*;

  localparam int LATENCY = 4 * 16 + 8;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [63:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [31:0] m_tdata;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [15:0] cfg_data;

  int send_idle;
  int recv_stall;
  bit hold_req;
  int sent;
  clip_scoreboard sb;

  line_endpoint_clipper dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** line_endpoint_clipper: FAILED **");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int hold;
    hold = 0;
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold = 400;
      end
      if (hold > 0) begin
        m_tready <= 0;
        hold--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_segment(s_tdata);
      if (m_tvalid && m_tready) sb.check_point(m_tdata);
    end
  end

  task automatic send_segment(logic [63:0] seg);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= seg;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_rect(logic signed [15:0] l, logic signed [15:0] t,
                          logic signed [15:0] r, logic signed [15:0] b);
    write_reg(REG_LEFT, l);
    write_reg(REG_TOP, t);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    sb.set_rect(l, t, r, b);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(65535));
      3: return 16'($urandom_range(65535));
      default: return 16'(int'($urandom_range(800)) - 400);
    endcase
  endfunction

  function automatic logic [63:0] random_segment();
    logic [15:0] sx, sy, ex, ey;
    sx = pick_coord();
    sy = pick_coord();
    ex = pick_coord();
    ey = pick_coord();
    if ($urandom_range(9) == 0) ex = sx;
    if ($urandom_range(9) == 0) ey = sy;
    return {ey, ex, sy, sx};
  endfunction

  initial begin
    logic signed [15:0] a, b, c, d;
    sb = new();
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    cfg_we = 0;
    cfg_index = REG_LEFT;
    cfg_data = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset rectangle
    send_segment({16'sd10, 16'sd10, 16'sd5, 16'sd5});
    send_segment({16'sd100, -16'sd50, 16'sd100, 16'sd100});
    send_segment({-16'sd50, 16'sd100, 16'sd100, 16'sd100});
    send_segment({16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    send_segment({16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
    send_segment({16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    send_segment({16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
    send_segment({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_segment({-16'sd1, -16'sd1, 16'sd5, 16'sd5});
    send_segment({-16'sd3, 16'sd5, -16'sd3, 16'sd5});
    send_segment({16'h8000, -16'sd20000, 16'h7fff, 16'sd30000});
    send_segment({-16'sd32000, 16'sd1, 16'sd32000, 16'sd2});
    send_segment({16'hffff, 16'hffff, 16'hffff, 16'hffff});
    drain();
    // inverted rectangle, and a tiny one
    set_rect(16'sd100, 16'sd100, -16'sd100, -16'sd100);
    send_segment({16'sd300, 16'sd300, 16'sd0, 16'sd0});
    send_segment({-16'sd300, -16'sd300, 16'sd0, 16'sd0});
    send_segment({16'sd0, 16'sd300, 16'sd0, 16'sd0});
    drain();
    set_rect(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_segment({16'sd7, 16'sd3, -16'sd2, -16'sd9});
    send_segment({16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_rect(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        1: set_rect(-16'sd200, -16'sd150, 16'sd200, 16'sd150);
        2: set_rect(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        default: begin
          a = 16'($urandom_range(65535));
          b = 16'($urandom_range(65535));
          c = 16'($urandom_range(65535));
          d = 16'($urandom_range(65535));
          if ($urandom_range(3) != 0) begin
            if (a > c) {a, c} = {c, a};
            if (b > d) {b, d} = {d, b};
          end
          set_rect(a, b, c, d);
        end
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 80; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 80; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      if (ph == 0) hold_req = 1;
      for (int i = 0; i < 225; i++) begin
        if (ph == 1 && i == 100) drain();
        send_segment(random_segment());
      end
      drain();
    end

    $display("Clipped %0d segments over nine rectangles, incl. full-range, point and inverted,",
             sent);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (sb.fails == 0 && sb.checked == sent) begin
      $display("** line_endpoint_clipper: PASSED **");
    end else begin
      $display("** line_endpoint_clipper: FAILED **");
    end
    $finish;
  end
endmodule

>>> line_endpoint_clipper.f
+incdir+src
src/lec_pkg.sv
src/lec_div.sv
src/lec_axis.sv
src/line_endpoint_clipper.sv
bench/tb_line_endpoint_clipper.sv
